>>> src/keypad_code_lock_fsm_assert.svh
// ----------------------------------------------------------------------------
// Keypad code lock assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_FSM_ASSERT_SVH
`define KEYPAD_CODE_LOCK_FSM_ASSERT_SVH

// condition holds at every edge
`define KCL_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("keypad code lock check failed");

// antecedent implies consequent in the next cycle
`define KCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keypad code lock check failed");

`endif

>>> src/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Key, mode and event codes and shared types of the keypad code lock.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

	localparam logic [3:0] K_BACK  = 4'd11;
	localparam logic [3:0] K_CLEAR = 4'd12;
	localparam logic [3:0] K_DEL   = 4'd13;

	localparam logic [3:0] K_OPT_AC       = 4'd1;
	localparam logic [3:0] K_OPT_ADMIN    = 4'd2;
	localparam logic [3:0] K_OPT_NEW_SYS  = 4'd1;
	localparam logic [3:0] K_OPT_NEW_AC   = 4'd2;
	localparam logic [3:0] K_OPT_NEW_ADM  = 4'd3;

	localparam logic [3:0] M_LOCKED  = 4'd0;
	localparam logic [3:0] M_MENU    = 4'd1;
	localparam logic [3:0] M_AC_IN   = 4'd2;
	localparam logic [3:0] M_ADM_IN  = 4'd3;
	localparam logic [3:0] M_CHG     = 4'd4;
	localparam logic [3:0] M_NEW_SYS = 4'd5;
	localparam logic [3:0] M_NEW_AC  = 4'd6;
	localparam logic [3:0] M_NEW_ADM = 4'd7;
	localparam logic [3:0] M_AC_RUN  = 4'd8;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_CORRECT = 3'd1;
	localparam logic [2:0] EV_WRONG   = 3'd2;
	localparam logic [2:0] EV_LOCKOUT = 3'd3;
	localparam logic [2:0] EV_CHANGED = 3'd4;

	typedef struct packed {
		logic [3:0] mode;
		logic [3:0] tries;
	} kcl_ctl_t;

	typedef struct packed {
		logic sys;
		logic ac;
		logic adm;
	} kcl_we_t;

	typedef struct packed {
		logic [3:0] mode;
		logic [2:0] keys;
		logic [2:0] event_res;
		logic [3:0] tries;
	} kcl_res_t;

endpackage

`default_nettype wire

>>> src/kcl_step.sv
// ----------------------------------------------------------------------------
// kcl_step
// Next-state logic for one key: entry editing, code compare, try counting,
// menu moves and code store enables.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_step
	import kcl_pkg::*;
#(
	parameter int CODE_LEN = 4
) (
	input  wire logic [3:0]                          key,
	input  wire kcl_ctl_t                            ctl_cur,
	input  wire logic [4*CODE_LEN-1:0]               buf_cur,
	input  wire logic [$clog2(CODE_LEN+1)-1:0]       cnt_cur,
	input  wire logic [4*CODE_LEN-1:0]               sys_code,
	input  wire logic [4*CODE_LEN-1:0]               ac_code,
	input  wire logic [4*CODE_LEN-1:0]               adm_code,
	input  wire logic [3:0]                          max_tries,
	output kcl_ctl_t                                 ctl_nxt,
	output logic [4*CODE_LEN-1:0]                    buf_nxt,
	output logic [$clog2(CODE_LEN+1)-1:0]            cnt_nxt,
	output logic [4*CODE_LEN-1:0]                    code_new,
	output kcl_we_t                                  we,
	output kcl_res_t                                 res
);

	localparam int BW = 4 * CODE_LEN;
	localparam int CW = $clog2(CODE_LEN + 1);

	logic [BW+3:0] app;
	logic [BW-1:0] ebuf;
	logic [CW-1:0] ecnt;
	logic          back_ok;
	logic          back;
	logic          done;
	logic [3:0]    tries_inc;
	logic [BW-1:0] nbuf;
	logic [CW-1:0] ncnt;
	logic [2:0]    ev;
	kcl_ctl_t      nctl;
	kcl_we_t       nwe;

	assign back_ok = (ctl_cur.mode != M_LOCKED) && (ctl_cur.mode <= M_AC_RUN);
	assign app = {buf_cur, key};
	assign tries_inc = ctl_cur.tries + 4'd1;

	// entry editing
	always_comb begin
		ebuf = buf_cur;
		ecnt = cnt_cur;
		back = 1'b0;
		done = 1'b0;
		if (key == K_DEL) begin
			if (cnt_cur != '0) begin
				ebuf = buf_cur >> 4;
				ecnt = cnt_cur - CW'(1);
			end
		end else if (key == K_CLEAR) begin
			ebuf = '0;
			ecnt = '0;
		end else if (key == K_BACK && back_ok) begin
			ebuf = '0;
			ecnt = '0;
			back = 1'b1;
		end else begin
			ebuf = app[BW-1:0];
			ecnt = cnt_cur + CW'(1);
			done = (ecnt == CW'(CODE_LEN));
		end
	end

	always_comb begin
		nctl = ctl_cur;
		nbuf = buf_cur;
		ncnt = cnt_cur;
		ev   = EV_NONE;
		nwe  = '0;
		unique case (ctl_cur.mode)
			M_MENU: begin
				if (key == K_OPT_AC) begin
					nctl.mode = M_AC_IN;
				end else if (key == K_OPT_ADMIN) begin
					nctl.mode = M_ADM_IN;
				end else if (key == K_BACK) begin
					nctl.mode = M_LOCKED;
					nbuf = '0;
					ncnt = '0;
				end
			end
			M_CHG: begin
				if (key == K_OPT_NEW_SYS) begin
					nctl.mode = M_NEW_SYS;
				end else if (key == K_OPT_NEW_AC) begin
					nctl.mode = M_NEW_AC;
				end else if (key == K_OPT_NEW_ADM) begin
					nctl.mode = M_NEW_ADM;
				end else if (key == K_BACK) begin
					nctl.mode = M_MENU;
					nbuf = '0;
					ncnt = '0;
				end
			end
			M_AC_RUN: begin
				if (key == K_BACK) begin
					nctl.mode = M_MENU;
					nbuf = '0;
					ncnt = '0;
				end
			end
			M_AC_IN, M_ADM_IN: begin
				nbuf = ebuf;
				ncnt = ecnt;
				if (back) begin
					nctl.mode = (ctl_cur.mode == M_AC_IN) ? M_LOCKED : M_MENU;
				end else if (done) begin
					if (ebuf == ((ctl_cur.mode == M_AC_IN) ? ac_code : adm_code)) begin
						nctl.tries = '0;
						ev = EV_CORRECT;
						nctl.mode = (ctl_cur.mode == M_AC_IN) ? M_AC_RUN : M_CHG;
					end else if (tries_inc >= max_tries) begin
						nctl.tries = '0;
						nctl.mode = M_LOCKED;
						ev = EV_LOCKOUT;
					end else begin
						nctl.tries = tries_inc;
						ev = EV_WRONG;
					end
				end
			end
			M_NEW_SYS, M_NEW_AC, M_NEW_ADM: begin
				nbuf = ebuf;
				ncnt = ecnt;
				if (back) begin
					nctl.mode = M_CHG;
				end else if (done) begin
					nwe.sys = (ctl_cur.mode == M_NEW_SYS);
					nwe.ac  = (ctl_cur.mode == M_NEW_AC);
					nwe.adm = (ctl_cur.mode == M_NEW_ADM);
					ev = EV_CHANGED;
					nctl.mode = M_MENU;
				end
			end
			default: begin
				nctl.mode = M_LOCKED;
				nbuf = ebuf;
				ncnt = ecnt;
				if (done) begin
					if (ebuf == sys_code) begin
						nctl.tries = '0;
						ev = EV_CORRECT;
						nctl.mode = M_MENU;
					end else if (tries_inc >= max_tries) begin
						nctl.tries = '0;
						ev = EV_LOCKOUT;
					end else begin
						nctl.tries = tries_inc;
						ev = EV_WRONG;
					end
				end
			end
		endcase
	end

	assign ctl_nxt  = nctl;
	assign buf_nxt  = done ? '0 : nbuf;
	assign cnt_nxt  = done ? '0 : ncnt;
	assign code_new = ebuf;
	assign we       = nwe;
	assign res      = {nctl.mode, 3'(ncnt), ev, nctl.tries};

endmodule

`default_nettype wire

>>> src/keypad_code_lock_fsm.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_fsm
// Multi-level keypad code lock: one key in, one status result out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, key_code) takes one key per request.
//   Output channel (out_valid/out_ready) returns mode, keys_entered,
//   event_res and wrong_tries for every key, in order.
//   Config channel (cfg_valid/cfg_ready, max_wrong_tries) sets the wrong-try
//   limit; cfg_ready is always high. Write it only while no key is in flight.
//   Path: an accepted key passes the input register, the lock update and
//   the result register. Throughput: one key per cycle while out_ready is
//   high; the input register and the result register each hold one request.
//   Stall: while out_ready is low the result holds; one more key is taken
//   into the input register, then in_ready drops until the result drains.
//   Reset: locked mode, empty entry, try count 0, limit 5, system code 5555,
//   AC code 8888, admin code 0000 (one digit per key of CODE_LEN).
// ----------------------------------------------------------------------------
`default_nettype none
`include "keypad_code_lock_fsm_assert.svh"

module keypad_code_lock_fsm
	import kcl_pkg::*;
#(
	parameter int CODE_LEN = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [3:0] key_code,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      mode,
	output logic [2:0]      keys_entered,
	output logic [2:0]      event_res,
	output logic [3:0]      wrong_tries,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] max_wrong_tries
);

	localparam int BW = 4 * CODE_LEN;
	localparam int CW = $clog2(CODE_LEN + 1);

	logic          valid_s1;
	logic [3:0]    key_s1;
	logic          valid_s2;
	kcl_res_t      res_s2;
	logic          advance;

	kcl_ctl_t      ctl_q;
	logic [BW-1:0] buf_q;
	logic [CW-1:0] cnt_q;
	logic [BW-1:0] sys_q;
	logic [BW-1:0] ac_q;
	logic [BW-1:0] adm_q;
	logic [3:0]    max_q;

	kcl_ctl_t      ctl_nxt;
	logic [BW-1:0] buf_nxt;
	logic [CW-1:0] cnt_nxt;
	logic [BW-1:0] code_new;
	kcl_we_t       we;
	kcl_res_t      res;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_s1 <= key_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 4'd5;
		end else if (cfg_valid) begin
			max_q <= max_wrong_tries;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{mode: M_LOCKED, tries: 4'd0};
			buf_q <= '0;
			cnt_q <= '0;
			sys_q <= {CODE_LEN{4'h5}};
			ac_q  <= {CODE_LEN{4'h8}};
			adm_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
			buf_q <= buf_nxt;
			cnt_q <= cnt_nxt;
			if (we.sys) begin
				sys_q <= code_new;
			end
			if (we.ac) begin
				ac_q <= code_new;
			end
			if (we.adm) begin
				adm_q <= code_new;
			end
		end
	end

	kcl_step #(
		.CODE_LEN (CODE_LEN)
	) u_step (
		.key       (key_s1),
		.ctl_cur   (ctl_q),
		.buf_cur   (buf_q),
		.cnt_cur   (cnt_q),
		.sys_code  (sys_q),
		.ac_code   (ac_q),
		.adm_code  (adm_q),
		.max_tries (max_q),
		.ctl_nxt   (ctl_nxt),
		.buf_nxt   (buf_nxt),
		.cnt_nxt   (cnt_nxt),
		.code_new  (code_new),
		.we        (we),
		.res       (res)
	);

	assign out_valid    = valid_s2;
	assign mode         = res_s2.mode;
	assign keys_entered = res_s2.keys;
	assign event_res    = res_s2.event_res;
	assign wrong_tries  = res_s2.tries;

	`KCL_ASSERT_NEXT(a_result_after_step, advance, valid_s2)
	`KCL_ASSERT_NEXT(a_key_held_on_stall, valid_s1 && !advance,
		valid_s1 && $stable(key_s1))
	`KCL_ASSERT_NEXT(a_lockout_locks, advance && res.event_res == EV_LOCKOUT,
		ctl_q.mode == M_LOCKED && ctl_q.tries == 4'd0)
	`KCL_ASSERT_ALWAYS(a_count_below_len, cnt_q < CW'(CODE_LEN))
	`KCL_ASSERT_ALWAYS(a_mode_in_range, ctl_q.mode <= M_AC_RUN)

endmodule

`default_nettype wire

>>> bench/lock_status_checker.sv
// ----------------------------------------------------------------------------
// lock_status_checker
// Watches the key, result and limit channels of the keypad code lock, keeps
// its own model of the lock, and compares every result field by field with
// the status predicted for the oldest outstanding key request.
// ----------------------------------------------------------------------------
module lock_status_checker
	import kcl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  key_code,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  mode,
	input  logic [2:0]  keys_entered,
	input  logic [2:0]  event_res,
	input  logic [3:0]  wrong_tries,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  max_wrong_tries,
	output int          pending_count,
	output int          fail_count,
	output int          n_results,
	output int          n_unlock,
	output int          n_wrong,
	output int          n_lockout,
	output int          n_changed,
	output logic [15:0] sys_code_now,
	output logic [15:0] ac_code_now,
	output logic [15:0] adm_code_now
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS_PER_CODE = 4;

	typedef enum logic [1:0] {ENTRY_OPEN, ENTRY_DONE, ENTRY_BACK} entry_act_e;

	logic [3:0]  lock_mode;
	logic [15:0] entry_keys;
	logic [2:0]  entry_cnt;
	logic [3:0]  try_cnt;
	logic [3:0]  try_limit;
	logic [15:0] sys_code;
	logic [15:0] ac_code;
	logic [15:0] adm_code;

	kcl_res_t status_q [$];
	kcl_res_t want;
	int       mismatches;
	int       results_seen;
	int       unlocks, wrongs, lockouts, changes;

	task automatic report_mismatch(string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	function automatic void clear_entry();
		entry_keys = '0;
		entry_cnt  = '0;
	endfunction

	function automatic entry_act_e edit_entry(logic [3:0] key, bit back_ok);
		if (key == K_DEL) begin
			if (entry_cnt != 0) begin
				entry_keys = entry_keys >> 4;
				entry_cnt  = entry_cnt - 3'd1;
			end
			return ENTRY_OPEN;
		end
		if (key == K_CLEAR) begin
			clear_entry();
			return ENTRY_OPEN;
		end
		if (key == K_BACK && back_ok) begin
			clear_entry();
			return ENTRY_BACK;
		end
		entry_keys = {entry_keys[11:0], key};
		entry_cnt  = entry_cnt + 3'd1;
		return (entry_cnt >= KEYS_PER_CODE) ? ENTRY_DONE : ENTRY_OPEN;
	endfunction

	function automatic logic [2:0] count_wrong();
		try_cnt = try_cnt + 4'd1;
		if (try_cnt >= try_limit) begin
			try_cnt   = '0;
			lock_mode = M_LOCKED;
			return EV_LOCKOUT;
		end
		return EV_WRONG;
	endfunction

	function automatic kcl_res_t next_status(logic [3:0] key);
		kcl_res_t   r;
		entry_act_e act;
		logic [2:0] ev;
		ev = EV_NONE;
		case (lock_mode)
			M_MENU: begin
				if (key == K_OPT_AC) lock_mode = M_AC_IN;
				else if (key == K_OPT_ADMIN) lock_mode = M_ADM_IN;
				else if (key == K_BACK) begin
					lock_mode = M_LOCKED;
					clear_entry();
				end
			end
			M_CHG: begin
				if (key == K_OPT_NEW_SYS) lock_mode = M_NEW_SYS;
				else if (key == K_OPT_NEW_AC) lock_mode = M_NEW_AC;
				else if (key == K_OPT_NEW_ADM) lock_mode = M_NEW_ADM;
				else if (key == K_BACK) begin
					lock_mode = M_MENU;
					clear_entry();
				end
			end
			M_AC_RUN: begin
				if (key == K_BACK) begin
					lock_mode = M_MENU;
					clear_entry();
				end
			end
			M_AC_IN, M_ADM_IN: begin
				act = edit_entry(key, 1'b1);
				if (act == ENTRY_BACK) begin
					lock_mode = (lock_mode == M_AC_IN) ? M_LOCKED : M_MENU;
				end else if (act == ENTRY_DONE) begin
					if (entry_keys == ((lock_mode == M_AC_IN) ? ac_code : adm_code)) begin
						try_cnt   = '0;
						ev        = EV_CORRECT;
						lock_mode = (lock_mode == M_AC_IN) ? M_AC_RUN : M_CHG;
					end else begin
						ev = count_wrong();
					end
				end
			end
			M_NEW_SYS, M_NEW_AC, M_NEW_ADM: begin
				act = edit_entry(key, 1'b1);
				if (act == ENTRY_BACK) begin
					lock_mode = M_CHG;
				end else if (act == ENTRY_DONE) begin
					if (lock_mode == M_NEW_SYS) sys_code = entry_keys;
					else if (lock_mode == M_NEW_AC) ac_code = entry_keys;
					else adm_code = entry_keys;
					ev        = EV_CHANGED;
					lock_mode = M_MENU;
				end
			end
			default: begin
				lock_mode = M_LOCKED;
				act = edit_entry(key, 1'b0);
				if (act == ENTRY_DONE) begin
					if (entry_keys == sys_code) begin
						try_cnt   = '0;
						ev        = EV_CORRECT;
						lock_mode = M_MENU;
					end else begin
						ev = count_wrong();
					end
				end
			end
		endcase
		r.mode      = lock_mode;
		r.keys      = entry_cnt;
		r.event_res = ev;
		r.tries     = try_cnt;
		if (entry_cnt >= KEYS_PER_CODE) clear_entry();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_mode = M_LOCKED;
			clear_entry();
			try_cnt   = '0;
			try_limit = 4'd5;
			sys_code  = 16'h5555;
			ac_code   = 16'h8888;
			adm_code  = 16'h0000;
			status_q.delete();
			mismatches   = 0;
			results_seen = 0;
			unlocks  = 0;
			wrongs   = 0;
			lockouts = 0;
			changes  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no request pending",
						results_seen));
				end else begin
					want = status_q.pop_front();
					if (mode !== want.mode)
						report_mismatch($sformatf("request %0d: mode %0d, expected %0d",
							results_seen, mode, want.mode));
					if (keys_entered !== want.keys)
						report_mismatch($sformatf("request %0d: keys_entered %0d, expected %0d",
							results_seen, keys_entered, want.keys));
					if (event_res !== want.event_res)
						report_mismatch($sformatf("request %0d: event_res %0d, expected %0d",
							results_seen, event_res, want.event_res));
					if (wrong_tries !== want.tries)
						report_mismatch($sformatf("request %0d: wrong_tries %0d, expected %0d",
							results_seen, wrong_tries, want.tries));
					case (want.event_res)
						EV_CORRECT: unlocks++;
						EV_WRONG:   wrongs++;
						EV_LOCKOUT: lockouts++;
						EV_CHANGED: changes++;
						default: ;
					endcase
				end
				results_seen++;
			end
			if (cfg_valid && cfg_ready) try_limit = max_wrong_tries;
			if (in_valid && in_ready) status_q.push_back(next_status(key_code));
		end
		pending_count <= status_q.size();
		fail_count    <= mismatches;
		n_results     <= results_seen;
		n_unlock      <= unlocks;
		n_wrong       <= wrongs;
		n_lockout     <= lockouts;
		n_changed     <= changes;
		sys_code_now  <= sys_code;
		ac_code_now   <= ac_code;
		adm_code_now  <= adm_code;
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the keypad code lock with a short directed walk through most modes,
// then random sessions: unlock attempts, wrong-code runs up to lockout, AC and
// admin entry, code changes and keypad noise, over several wrong-try limits.
// Both channels idle at random; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kcl_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 11;
	localparam int LIMIT_CYCLES = 600000;
	localparam int RANDOM_KEYS  = 1050;
	localparam int PHASES       = 6;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_TAIL   = 6;

	localparam logic [3:0] K_A    = 4'd10;
	localparam logic [3:0] K_STAR = 4'd14;
	localparam logic [3:0] K_HASH = 4'd15;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  key_code;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  mode;
	logic [2:0]  keys_entered;
	logic [2:0]  event_res;
	logic [3:0]  wrong_tries;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  max_wrong_tries;

	int          pending_count, fail_count, n_results;
	int          n_unlock, n_wrong, n_lockout, n_changed;
	logic [15:0] sys_code_now, ac_code_now, adm_code_now;

	int          keys_sent;
	int          limit_writes;
	int          hold_req;
	int          cycle_count;
	bit          calm;
	logic [3:0]  cur_limit;

	keypad_code_lock_fsm dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_code        (key_code),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mode            (mode),
		.keys_entered    (keys_entered),
		.event_res       (event_res),
		.wrong_tries     (wrong_tries),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.max_wrong_tries (max_wrong_tries)
	);

	lock_status_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.key_code        (key_code),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mode            (mode),
		.keys_entered    (keys_entered),
		.event_res       (event_res),
		.wrong_tries     (wrong_tries),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.max_wrong_tries (max_wrong_tries),
		.pending_count   (pending_count),
		.fail_count      (fail_count),
		.n_results       (n_results),
		.n_unlock        (n_unlock),
		.n_wrong         (n_wrong),
		.n_lockout       (n_lockout),
		.n_changed       (n_changed),
		.sys_code_now    (sys_code_now),
		.ac_code_now     (ac_code_now),
		.adm_code_now    (adm_code_now)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// four keys, none of them back, clear or delete
	function automatic logic [15:0] random_code();
		logic [15:0] c;
		logic [3:0]  k;
		c = '0;
		for (int i = 0; i < 4; i++) begin
			do k = 4'($urandom_range(0, 15));
			while (k == K_BACK || k == K_CLEAR || k == K_DEL);
			c = {c[11:0], k};
		end
		return c;
	endfunction

	task automatic send_key(logic [3:0] k);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_code <= k;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		keys_sent++;
	endtask

	// a stray digit fixed with delete now and then
	task automatic type_code(logic [15:0] code);
		for (int i = 3; i >= 0; i--) begin
			if ($urandom_range(0, 9) == 0) begin
				send_key(4'($urandom_range(0, 9)));
				send_key(K_DEL);
			end
			send_key(code[i*4 +: 4]);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk);
		while (pending_count != 0);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic set_limit(logic [3:0] v);
		drain();
		cfg_valid       <= 1'b1;
		max_wrong_tries <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_limit = v;
		limit_writes++;
	endtask

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d requests still pending",
			cycle_count, pending_count);
		$display("testbench NOT OK");
		$finish;
	end

	initial begin : result_sink
		int stall_left;
		int served;
		stall_left = 0;
		served     = 0;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req != served) begin
				served = hold_req;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (stall_left > 0 && !calm) begin
					out_ready <= 1'b0;
					stall_left--;
				end else begin
					out_ready <= 1'b1;
					stall_left = 0;
					if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
				end
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [3:0] directed [$];
		logic [3:0] limit_plan [PHASES];
		logic [3:0] target;
		int         phase_end;
		int         n_bad;
		int         pick;
		bit         held;

		arst_n          <= 1'b0;
		in_valid        <= 1'b0;
		key_code        <= '0;
		cfg_valid       <= 1'b0;
		max_wrong_tries <= 4'd5;
		keys_sent    = 0;
		limit_writes = 0;
		hold_req     = 0;
		calm         = 1'b0;
		held         = 1'b0;
		cur_limit    = 4'd5;

		limit_plan[0] = 4'd1;
		limit_plan[1] = 4'd15;
		limit_plan[2] = 4'd0;
		limit_plan[3] = 4'($urandom_range(2, 14));
		limit_plan[4] = 4'd3;
		limit_plan[5] = 4'd5;

		// B stored while locked, clear, delete on empty, unlock, AC run,
		// admin entry and a new admin code with the top key values
		directed = '{K_BACK, K_CLEAR, K_DEL, 4'd5, 4'd5, 4'd5, 4'd5,
			4'd0, K_OPT_AC, 4'd8, 4'd8, 4'd8, 4'd8, K_HASH, K_BACK,
			K_OPT_ADMIN, 4'd0, 4'd0, 4'd0, 4'd0,
			K_OPT_NEW_ADM, K_HASH, K_STAR, K_A, 4'd0};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_key(directed[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_limit(limit_plan[ph]);
			phase_end = keys_sent + RANDOM_KEYS / PHASES;
			while (keys_sent < phase_end) begin
				calm = ($urandom_range(0, 5) == 0);
				if (ph == 1 && !held) begin
					// sink holds off while keys keep coming back to back
					held = 1'b1;
					calm = 1'b1;
					hold_req++;
				end
				// back out to locked with an empty entry from any mode
				repeat (3) send_key(K_BACK);
				send_key(K_CLEAR);
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 8)) send_key(4'($urandom_range(0, 15)));
					continue;
				end
				n_bad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cur_limit + 1) : 0;
				repeat (n_bad) type_code(random_code());
				type_code(sys_code_now);
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					send_key(K_OPT_AC);
					if ($urandom_range(0, 4) == 0) type_code(random_code());
					type_code(ac_code_now);
					repeat ($urandom_range(0, 3)) send_key(4'($urandom_range(0, 10)));
					send_key(K_BACK);
				end else if (pick < 9) begin
					send_key(K_OPT_ADMIN);
					if ($urandom_range(0, 4) == 0) type_code(random_code());
					type_code(adm_code_now);
					case ($urandom_range(0, 2))
						0: target = K_OPT_NEW_SYS;
						1: target = K_OPT_NEW_AC;
						default: target = K_OPT_NEW_ADM;
					endcase
					if ($urandom_range(0, 5) == 0) begin
						send_key(target);
						send_key(4'($urandom_range(0, 9)));
						send_key(K_BACK);
					end
					if ($urandom_range(0, 7) == 0) send_key(K_HASH);
					send_key(target);
					type_code(random_code());
				end else begin
					send_key(K_BACK);
				end
			end
		end

		drain();
		$display("covered %0d key requests, %0d results checked, %0d limit writes",
			keys_sent, n_results, limit_writes);
		$display("events: %0d unlocks, %0d wrong codes, %0d lockouts, %0d code changes",
			n_unlock, n_wrong, n_lockout, n_changed);
		if (fail_count == 0 && pending_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/kcl_pkg.sv
src/kcl_step.sv
src/keypad_code_lock_fsm.sv
bench/lock_status_checker.sv
bench/testbench.sv
